FILE: sv/tcr_pkg.sv
// Shared types and constants for the target/clue rule table.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package tcr_pkg;

  localparam int NUM_TARGETS      = 64;
  localparam int CLUES_PER_TARGET = 8;

  localparam int ID_W     = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_O_W = 6;
  localparam int CLUE_O_W = 4;
  localparam int TGT_O_W  = 7;

  localparam int SLOT_W  = $clog2(NUM_TARGETS);
  localparam int CNT_W   = $clog2(CLUES_PER_TARGET + 1);
  localparam int TCNT_W  = $clog2(NUM_TARGETS + 1);
  localparam int CDEPTH  = NUM_TARGETS * CLUES_PER_TARGET;
  localparam int CADDR_W = $clog2(CDEPTH);

  localparam logic [ID_W-1:0] FREE_ID = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_INVALID    = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_TABLE_FULL = 3'd3,
    STAT_CLUES_FULL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } cam_wr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
  } cam_res_t;

endpackage

FILE: sv/tcr_target_cam.sv
// Target id store with parallel match and first-free search.
// Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_target_cam import tcr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] search_id_i,
  input  cam_wr_t         wr_i,
  output cam_res_t        res_o
);

  logic [ID_W-1:0]        ids_q [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] valid_q;
  logic [NUM_TARGETS-1:0] match;

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      ids_q[wr_i.slot] <= wr_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set) begin
      valid_q[wr_i.slot] <= 1'b1;
    end else if (wr_i.clr) begin
      valid_q[wr_i.slot] <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TARGETS; i++) begin
      match[i] = valid_q[i] && (ids_q[i] == search_id_i);
    end
  end

  // lowest index wins
  always_comb begin
    res_o = '0;
    res_o.hit     = |match;
    res_o.free_ok = ~&valid_q;
    for (int i = NUM_TARGETS - 1; i >= 0; i--) begin
      if (match[i]) begin
        res_o.hit_slot = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        res_o.free_slot = SLOT_W'(i);
      end
    end
  end

endmodule

FILE: sv/tcr_count_ram.sv
// Per-target clue count memory, one write and one registered read port.
// Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_count_ram import tcr_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [CNT_W-1:0]  wdata_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [CNT_W-1:0]  rdata_o
);

  logic [CNT_W-1:0] mem [NUM_TARGETS];
  logic [CNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcr_clue_store.sv
// Clue id and flags storage, one row of slots per target entry.
// Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_clue_store import tcr_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [CADDR_W-1:0] addr_i,
  input  logic [ID_W-1:0]    clue_id_i,
  input  logic signed [31:0] clue_flags_i
);

  logic [ID_W-1:0]    clue_ids [CDEPTH];
  logic signed [31:0] flag_words [CDEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      clue_ids[addr_i]   <= clue_id_i;
      flag_words[addr_i] <= clue_flags_i;
    end
  end

endmodule

FILE: sv/target_clue_rule_table_unit.sv
// Target/clue rule table: insert, delete and lookup of target entries.
// Each item passes the id search, the count memory read and the write-back
// step in turn; a new item is taken only after the last one is written back.
// Reset clears all entry valid bits, the target count and the handshake
// state at once; the block is ready for an item straight out of reset.
// Depends on tcr_pkg, tcr_target_cam, tcr_count_ram, tcr_clue_store.
`timescale 1ns / 1ps

module target_clue_rule_table_unit import tcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [ID_W-1:0]     target_id_i,
  input  logic [ID_W-1:0]     clue_id_i,
  input  logic signed [31:0]  clue_flags_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_O_W-1:0] slot_index_o,
  output logic [CLUE_O_W-1:0] clue_total_o,
  output logic [TGT_O_W-1:0]  target_total_o
);

  state_e state_q, state_d;

  logic [OP_W-1:0]    op_q;
  logic [ID_W-1:0]    tid_q;
  logic [ID_W-1:0]    cid_q;
  logic signed [31:0] flags_q;

  logic              hit_q, hit_d;
  logic              free_ok_q, free_ok_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [TCNT_W-1:0] tcount_q, tcount_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_O_W-1:0] oslot_q, oslot_d;
  logic [CLUE_O_W-1:0] oclue_q, oclue_d;

  logic accept, commit, capture;
  logic [CNT_W-1:0] cnt_rd, cnt_eff;

  cam_wr_t  cam_wr;
  cam_res_t cam_res;

  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_wdata;
  logic               clue_we;
  logic [CADDR_W-1:0] clue_addr;

  tcr_target_cam u_cam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .search_id_i (tid_q),
    .wr_i        (cam_wr),
    .res_o       (cam_res)
  );

  tcr_count_ram u_cnt (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (slot_q),
    .wdata_i (cnt_wdata),
    .raddr_i (slot_q),
    .rdata_o (cnt_rd)
  );

  tcr_clue_store u_clue (
    .clk_i        (clk_i),
    .we_i         (clue_we),
    .addr_i       (clue_addr),
    .clue_id_i    (cid_q),
    .clue_flags_i (flags_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: state_d = ST_READ;
      ST_READ:   state_d = ST_EXEC;
      ST_EXEC:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    capture    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: capture    = 1'b1;
      ST_READ:   ;
      ST_EXEC:   commit     = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // hold search results
  always_comb begin
    hit_d     = hit_q;
    free_ok_d = free_ok_q;
    slot_d    = slot_q;
    if (capture) begin
      hit_d     = cam_res.hit;
      free_ok_d = cam_res.free_ok;
      slot_d    = cam_res.hit ? cam_res.hit_slot : cam_res.free_slot;
    end
  end

  assign cnt_eff   = hit_q ? cnt_rd : '0;
  assign cnt_wdata = cnt_eff + CNT_W'(1);
  assign clue_addr = CADDR_W'(slot_q) * CADDR_W'(CLUES_PER_TARGET) + CADDR_W'(cnt_eff);

  // decide, write back, form result
  always_comb begin
    cam_wr      = '0;
    cam_wr.slot = slot_q;
    cam_wr.id   = tid_q;
    cnt_we      = 1'b0;
    clue_we     = 1'b0;
    tcount_d    = tcount_q;
    status_d    = status_q;
    oslot_d     = oslot_q;
    oclue_d     = oclue_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (commit) begin
      out_valid_d = 1'b1;
      status_d    = STAT_INVALID;
      oslot_d     = '0;
      oclue_d     = '0;
      if (tid_q != FREE_ID) begin
        case (op_q)
          OP_INSERT: begin
            if (cid_q == FREE_ID) begin
              status_d = STAT_INVALID;
            end else if (!hit_q && !free_ok_q) begin
              status_d = STAT_TABLE_FULL;
            end else if (cnt_eff >= CNT_W'(CLUES_PER_TARGET)) begin
              status_d = STAT_CLUES_FULL;
              oclue_d  = CLUE_O_W'(cnt_eff);
            end else begin
              status_d   = STAT_OK;
              oslot_d    = SLOT_O_W'(slot_q);
              oclue_d    = CLUE_O_W'(cnt_wdata);
              cnt_we     = 1'b1;
              clue_we    = 1'b1;
              cam_wr.set = !hit_q;
              if (!hit_q) begin
                tcount_d = tcount_q + TCNT_W'(1);
              end
            end
          end
          OP_DELETE: begin
            if (!hit_q) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              status_d   = STAT_OK;
              oslot_d    = SLOT_O_W'(slot_q);
              cam_wr.clr = 1'b1;
              if (tcount_q != '0) begin
                tcount_d = tcount_q - TCNT_W'(1);
              end
            end
          end
          OP_LOOKUP: begin
            if (!hit_q) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              status_d = STAT_OK;
              oslot_d  = SLOT_O_W'(slot_q);
              oclue_d  = CLUE_O_W'(cnt_eff);
            end
          end
          default: status_d = STAT_INVALID;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tcount_q    <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_ok_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tcount_q    <= tcount_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      free_ok_q   <= free_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      tid_q   <= target_id_i;
      cid_q   <= clue_id_i;
      flags_q <= clue_flags_i;
    end
    slot_q   <= slot_d;
    status_q <= status_d;
    oslot_q  <= oslot_d;
    oclue_q  <= oclue_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = oslot_q;
  assign clue_total_o   = oclue_q;
  assign target_total_o = TGT_O_W'(tcount_q);

endmodule
